/* design/wc2_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, constants and the square-root step for the Wendland C2 weight pipeline.
package wc2_pkg;

  // Field widths.
  localparam int COORD_WIDTH      = 24;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WEIGHT_W         = WEIGHT_FRAC_BITS + 1;
  localparam int INV_W            = 32;

  // Fixed-point fractions: coordinates, reciprocal radius and polynomial work values.
  localparam int COORD_FRAC = 12;
  localparam int INV_FRAC   = 20;
  localparam int PROD_FRAC  = COORD_FRAC + INV_FRAC;
  localparam int WORK_FRAC  = 30;

  // Distance datapath widths.
  localparam int SQ_W   = 2 * COORD_WIDTH;
  localparam int RAD_W  = SQ_W + 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int PROD_W = ROOT_W + INV_W;

  // Polynomial datapath widths.
  localparam int X_W = WORK_FRAC;
  localparam int T_W = WORK_FRAC + 1;
  localparam int P_W = WORK_FRAC + 3;

  // Square-root unrolling: iterations handled by each pipeline stage.
  localparam int SQRT_PER_STAGE = 4;
  localparam int SQRT_STAGES    = (ROOT_W + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

  // Pipeline stage positions.
  localparam int ST_DIFF  = 0;
  localparam int ST_SQ    = 1;
  localparam int ST_SUM   = 2;
  localparam int ST_SQRT0 = 3;
  localparam int ST_PROD  = ST_SQRT0 + SQRT_STAGES;
  localparam int ST_X     = ST_PROD + 1;
  localparam int ST_T2    = ST_X + 1;
  localparam int ST_T4    = ST_T2 + 1;
  localparam int ST_OUT   = ST_T4 + 1;
  localparam int N_STAGES = ST_OUT + 1;

  // Configuration map.
  localparam int PADDR_W = 3;
  localparam logic REG_INV_RADIUS = 1'b0;
  localparam logic [INV_W-1:0] INV_RADIUS_RESET = INV_W'(1048576);

  // Stream widths.
  localparam int S_TDATA_W = ((6 * COORD_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_W = ((WEIGHT_W + 7) / 8) * 8;

  // State carried through the restoring square root.
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  // One restoring square-root iteration: brings down two radicand bits.
  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t            r;
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    rem2   = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial  = {1'b0, s.root, 2'b01};
    r.rad  = {s.rad[RAD_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* design/wendland_c2_rbf_weight.sv */
`timescale 1ns / 1ps
// Wendland C2 radial basis weight, fully pipelined over 15 register stages.
// Throughput: one request per cycle; each stage advances on its own, so bubbles close
// up and input is taken while a finished weight waits, as long as some stage is free.
// Reset clears all stage valid bits and sets inv_radius to 1.0 (Q12.20).
module wendland_c2_rbf_weight
  import wc2_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration port.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [INV_W-1:0]     pwdata,
  output logic [INV_W-1:0]     prdata,
  output logic                 pready,
  // Point pair requests.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // point_x, point_y, point_z, center_x, center_y, center_z (from bit 0 up)
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // Weights.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // weight, then zero fill (from bit 0 up)
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam logic [T_W-1:0] ONE_T = T_W'(1) << WORK_FRAC;
  localparam logic [P_W-1:0] ONE_P = P_W'(1) << WORK_FRAC;

  logic [INV_W-1:0]    inv_radius_q;
  logic [N_STAGES-1:0] v_q;
  logic [N_STAGES-1:0] en;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_INV_RADIUS) ? inv_radius_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_radius_q <= INV_RADIUS_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_INV_RADIUS)) begin
      inv_radius_q <= pwdata;
    end
  end

  // Stage advance: a stage loads when it is empty or the stage after it moves on.
  always_comb begin
    en[N_STAGES-1] = !v_q[N_STAGES-1] || m_axis_tready;
    for (int k = N_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[ST_DIFF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < N_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 0: absolute coordinate differences.
  logic signed [COORD_WIDTH-1:0] pt [3];
  logic signed [COORD_WIDTH-1:0] ct [3];
  logic signed [COORD_WIDTH:0]   diff [3];
  logic [COORD_WIDTH-1:0]        ad_d [3];
  logic [COORD_WIDTH-1:0]        ad_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i]   = s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH];
      ct[i]   = s_axis_tdata[(i+3)*COORD_WIDTH +: COORD_WIDTH];
      diff[i] = (COORD_WIDTH+1)'(pt[i]) - (COORD_WIDTH+1)'(ct[i]);
      ad_d[i] = diff[i][COORD_WIDTH] ? COORD_WIDTH'(-diff[i]) : diff[i][COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_DIFF]) begin
      ad_q <= ad_d;
    end
  end

  // Stage 1: squares.
  logic [SQ_W-1:0] sq_q [3];

  always_ff @(posedge clk_i) begin
    if (en[ST_SQ]) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SQ_W'(ad_q[i]) * SQ_W'(ad_q[i]);
      end
    end
  end

  // Stage 2: sum of squares, the radicand.
  logic [RAD_W-1:0] rad_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_SUM]) begin
      rad_q <= RAD_W'(sq_q[0]) + RAD_W'(sq_q[1]) + RAD_W'(sq_q[2]);
    end
  end

  // Square-root stages, a few restoring iterations in each.
  sqrt_t sr_in  [SQRT_STAGES];
  sqrt_t sr_out [SQRT_STAGES];
  sqrt_t sr_q   [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    if (g == 0) begin : g_first
      assign sr_in[g] = '{rad: rad_q, rem: '0, root: '0};
    end else begin : g_next
      assign sr_in[g] = sr_q[g-1];
    end

    always_comb begin
      sr_out[g] = sr_in[g];
      for (int i = 0; i < SQRT_PER_STAGE; i++) begin
        if (g * SQRT_PER_STAGE + i < ROOT_W) begin
          sr_out[g] = sqrt_step(sr_out[g]);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[ST_SQRT0 + g]) begin
        sr_q[g] <= sr_out[g];
      end
    end
  end

  // Distance times reciprocal radius.
  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_PROD]) begin
      prod_q <= PROD_W'(sr_q[SQRT_STAGES-1].root) * PROD_W'(inv_radius_q);
    end
  end

  // Support test, x and 1 - x.
  logic           zero_x_q;
  logic [X_W-1:0] x_q;
  logic [T_W-1:0] t_q;
  logic [X_W-1:0] x_d;

  assign x_d = prod_q[PROD_FRAC-1 -: X_W];

  always_ff @(posedge clk_i) begin
    if (en[ST_X]) begin
      zero_x_q <= |prod_q[PROD_W-1:PROD_FRAC];
      x_q      <= x_d;
      t_q      <= ONE_T - T_W'(x_d);
    end
  end

  // (1 - x)^2.
  logic              zero_t2_q;
  logic [X_W-1:0]    x_t2_q;
  logic [T_W-1:0]    t2_q;
  logic [2*T_W-1:0]  t_sq;

  assign t_sq = (2*T_W)'(t_q) * (2*T_W)'(t_q);

  always_ff @(posedge clk_i) begin
    if (en[ST_T2]) begin
      zero_t2_q <= zero_x_q;
      x_t2_q    <= x_q;
      t2_q      <= t_sq[WORK_FRAC +: T_W];
    end
  end

  // (1 - x)^4 and 1 + 4x.
  logic              zero_t4_q;
  logic [T_W-1:0]    t4_q;
  logic [P_W-1:0]    p_q;
  logic [2*T_W-1:0]  t2_sq;

  assign t2_sq = (2*T_W)'(t2_q) * (2*T_W)'(t2_q);

  always_ff @(posedge clk_i) begin
    if (en[ST_T4]) begin
      zero_t4_q <= zero_t2_q;
      t4_q      <= t2_sq[WORK_FRAC +: T_W];
      p_q       <= ONE_P + {1'b0, x_t2_q, 2'b00};
    end
  end

  // Final product, truncated to the output fraction.
  logic [WEIGHT_W-1:0]  weight_q;
  logic [T_W+P_W-1:0]   w_prod;

  assign w_prod = (T_W+P_W)'(t4_q) * (T_W+P_W)'(p_q);

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      weight_q <= zero_t4_q ? '0 : w_prod[2*WORK_FRAC-WEIGHT_FRAC_BITS +: WEIGHT_W];
    end
  end

  assign m_axis_tvalid = v_q[ST_OUT];
  assign m_axis_tdata  = M_TDATA_W'(weight_q);

  // An empty output stage lets every stage advance, so input is never blocked while it is empty.
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // The weight never exceeds 1.0.
  a_weight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (weight_q <= (WEIGHT_W'(1) << WEIGHT_FRAC_BITS)))
    else $error("weight above 1.0");

  // An accepted request occupies the first stage on the next cycle.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_q[ST_DIFF])
    else $error("accepted request lost at first stage");

  // A result leaving while the last stage before output holds one refills the output.
  a_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && v_q[ST_T4]) |=> m_axis_tvalid)
    else $error("output stage not refilled");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import wc2_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 5;
  localparam int PIPE_LATENCY    = 15;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int N_PHASES        = 16;
  localparam int ITEMS_PER_PHASE = 96;
  localparam int N_DIR           = 22;

  localparam longint COORD_MAX  = (longint'(1) << (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN  = -(longint'(1) << (COORD_WIDTH - 1));
  localparam longint COORD_SPAN = longint'(1) << COORD_WIDTH;
  localparam int     CMAX       = 8388607;
  localparam int     CMIN       = -8388608;
  localparam int     Q12_ONE    = 1 << COORD_FRAC;
  localparam int     W_ONE      = 1 << WEIGHT_FRAC_BITS;

  // One coordinate pair: index 0..2 point x/y/z, index 3..5 center x/y/z, from bit 0 up.
  typedef logic [COORD_WIDTH-1:0] coord_t;
  typedef coord_t [5:0] pair_t;

  // Where a directed row takes its expected weight from.
  typedef enum bit {BY_PREDICTOR, TYPED} weight_src_e;

  typedef struct {
    logic [INV_W-1:0]    inv;
    pair_t               pr;
    weight_src_e         src;
    logic [WEIGHT_W-1:0] weight;
  } row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [PADDR_W-1:0]   paddr         = '0;
  logic [INV_W-1:0]     pwdata        = '0;
  logic [INV_W-1:0]     prdata;
  logic                 pready;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  logic [WEIGHT_W-1:0] weights_due[$];
  logic [WEIGHT_W-1:0] weight_head;
  logic [INV_W-1:0]    inv_now = INV_RADIUS_RESET;
  int                  errors = 0;
  int                  cycles = 0;
  int                  burst_left = 0;
  bit                  steady = 1'b0;
  int                  ready_mode = 0;
  int                  mode_left = 0;
  int                  hold_left = 0;
  row_t                directed[N_DIR];

  wendland_c2_rbf_weight dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Expected weight: truncated integer distance, scaled by the reciprocal radius,
  // then the C2 polynomial in Q3.30 with truncation after every product.
  function automatic logic [WEIGHT_W-1:0] rbf_weight(pair_t pr, logic [INV_W-1:0] inv);
    longint      diff;
    logic [63:0] sum, root, rem, trial, prod, x, t, t2, t4, poly;
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      diff = longint'($signed(pr[k])) - longint'($signed(pr[k+3]));
      sum += 64'(diff * diff);
    end
    root = '0;
    rem  = '0;
    for (int pos = 62; pos >= 0; pos -= 2) begin
      rem   = (rem << 2) | ((sum >> pos) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    prod = (inv == '0) ? 64'd0 : root * 64'(inv);
    if (prod >= (64'd1 << PROD_FRAC)) return '0;
    x    = prod >> (PROD_FRAC - WORK_FRAC);
    t    = (64'd1 << WORK_FRAC) - x;
    t2   = (t * t) >> WORK_FRAC;
    t4   = (t2 * t2) >> WORK_FRAC;
    poly = (64'd1 << WORK_FRAC) + (x << 2);
    return WEIGHT_W'(((t4 * poly) >> WORK_FRAC) >> (WORK_FRAC - WEIGHT_FRAC_BITS));
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    return coord_t'(v);
  endfunction

  // Mostly points within reach of the support radius, plus coincident pairs,
  // pairs straddling the boundary and fully random coordinates.
  function automatic pair_t random_pair(logic [INV_W-1:0] inv);
    pair_t  pr;
    longint reach;
    longint off;
    int     axis;
    int     pick;
    reach = (inv == '0) ? COORD_SPAN : longint'(64'd1 << PROD_FRAC) / longint'(inv);
    if (reach > COORD_SPAN) reach = COORD_SPAN;
    pick = $urandom_range(0, 99);
    for (int k = 0; k < 6; k++) pr[k] = coord_t'($urandom);
    if (pick < 55) begin
      for (int k = 0; k < 3; k++) begin
        off   = longint'($urandom_range(0, 32'(2 * reach))) - reach;
        pr[k] = clamp_coord(longint'($signed(pr[k+3])) + off);
      end
    end else if (pick < 63) begin
      pr[2:0] = pr[5:3];
    end else if (pick < 75) begin
      pr[2:0] = pr[5:3];
      axis    = $urandom_range(0, 2);
      off     = reach + longint'($urandom_range(0, 4)) - 2;
      if ($urandom_range(0, 1) == 1) off = -off;
      pr[axis] = clamp_coord(longint'($signed(pr[axis+3])) + off);
    end
    return pr;
  endfunction

  function automatic row_t row(logic [INV_W-1:0] inv, int px, int py, int pz,
                               int cx, int cy, int cz, weight_src_e src, int w);
    row_t r;
    r.inv    = inv;
    r.pr     = {coord_t'(cz), coord_t'(cy), coord_t'(cx),
                coord_t'(pz), coord_t'(py), coord_t'(px)};
    r.src    = src;
    r.weight = WEIGHT_W'(w);
    return r;
  endfunction

  // Present one request, with random bursts and gaps on the sending side.
  task automatic send_pair(input pair_t pr, input logic [WEIGHT_W-1:0] want);
    int gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(pr);
    do @(posedge clk_i); while (!s_axis_tready);
    weights_due.push_back(want);
  endtask

  // Stop sending and wait until every pending weight has come out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (weights_due.size() != 0) @(posedge clk_i);
  endtask

  // Write the reciprocal radius, then read it back.
  task automatic set_inv_radius(input logic [INV_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(REG_INV_RADIUS) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== value) begin
      $error("inv_radius: expected %0d, actual %0d", value, prdata);
      errors++;
    end
    inv_now = value;
  endtask

  // Receiver stalls: phases of always ready, light and heavy random stalls, long holds.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= 1'($urandom_range(0, 1));
        default: begin
          if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            hold_left     <= $urandom_range(5, 40);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Compare each weight with the oldest pending one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (weights_due.size() == 0) begin
        $error("weight: expected none, actual %0d", m_axis_tdata[WEIGHT_W-1:0]);
        errors++;
      end else begin
        weight_head = weights_due.pop_front();
        if (m_axis_tdata[WEIGHT_W-1:0] !== weight_head) begin
          $error("weight: expected %0d, actual %0d", weight_head,
                 m_axis_tdata[WEIGHT_W-1:0]);
          errors++;
        end
      end
    end
  end

  initial begin
    pair_t            pr;
    logic [INV_W-1:0] next_inv;

    // Directed cases, grouped by reciprocal radius.
    directed = '{
      // Radius 1.0 after reset: coincident points, extremes, the support boundary.
      row(INV_RADIUS_RESET, 0, 0, 0, 0, 0, 0, TYPED, W_ONE),
      row(INV_RADIUS_RESET, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, TYPED, W_ONE),
      row(INV_RADIUS_RESET, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, TYPED, W_ONE),
      row(INV_RADIUS_RESET, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, TYPED, 0),
      row(INV_RADIUS_RESET, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, TYPED, 0),
      row(INV_RADIUS_RESET, Q12_ONE, 0, 0, 0, 0, 0, TYPED, 0),
      row(INV_RADIUS_RESET, Q12_ONE - 1, 0, 0, 0, 0, 0, BY_PREDICTOR, 0),
      row(INV_RADIUS_RESET, 0, 0, 0, -Q12_ONE, 0, 0, TYPED, 0),
      row(INV_RADIUS_RESET, Q12_ONE / 2, 0, 0, 0, 0, 0, BY_PREDICTOR, 0),
      row(INV_RADIUS_RESET, -1000, 2000, -1500, 1000, -500, 300, BY_PREDICTOR, 0),
      row(INV_RADIUS_RESET, 1, 0, 0, 0, 0, 0, BY_PREDICTOR, 0),
      row(INV_RADIUS_RESET, 2896, 2896, 0, 0, 0, 0, BY_PREDICTOR, 0),
      row(INV_RADIUS_RESET, 2897, 2897, 0, 0, 0, 0, BY_PREDICTOR, 0),
      // Zero reciprocal radius: every pair weighs 1.0.
      row('0, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, TYPED, W_ONE),
      row('0, 12345, 0, 0, 0, 0, 0, TYPED, W_ONE),
      // Smallest reciprocal radius: huge support.
      row(32'd1, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, BY_PREDICTOR, 0),
      row(32'd1, CMAX, 0, 0, CMIN, 0, 0, BY_PREDICTOR, 0),
      // Largest reciprocal radius: only distances of at most one LSB stay inside.
      row(32'hFFFF_FFFF, 1, 0, 0, 0, 0, 0, BY_PREDICTOR, 0),
      row(32'hFFFF_FFFF, 2, 0, 0, 0, 0, 0, TYPED, 0),
      row(32'hFFFF_FFFF, CMIN, CMAX, 77, CMIN, CMAX, 77, TYPED, W_ONE),
      // Radius 0.5.
      row(32'h0020_0000, Q12_ONE / 2, 0, 0, 0, 0, 0, TYPED, 0),
      row(32'h0020_0000, Q12_ONE / 4, 0, 0, 0, 0, 0, BY_PREDICTOR, 0)
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].inv != inv_now) begin
        settle();
        set_inv_radius(directed[i].inv);
      end
      send_pair(directed[i].pr, (directed[i].src == TYPED) ? directed[i].weight
                                                           : rbf_weight(directed[i].pr, inv_now));
    end

    // Random phases, each under its own reciprocal radius and sender pace.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0: next_inv = $urandom;
        1: next_inv = INV_RADIUS_RESET;
        2: next_inv = (32'd1 << $urandom_range(0, 31)) | 32'($urandom_range(0, 255));
        3: next_inv = $urandom_range(1, 4096);
        4: next_inv = $urandom_range(32'h0010_0000, 32'h0100_0000);
        default: next_inv = 32'hFFFF_FFFF - $urandom_range(0, 15);
      endcase
      if (ph == 0) next_inv = 32'd1;
      if (ph == 1) next_inv = 32'hFFFF_FFFF;
      settle();
      set_inv_radius(next_inv);
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pr = random_pair(inv_now);
        send_pair(pr, rbf_weight(pr, inv_now));
      end
    end

    settle();
    repeat (PIPE_LATENCY + 25) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
